/* sv/assert_macros.svh */
// Assertion helpers for the RTL; each expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CHECK_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check a consequence in the cycle after a trigger.
`define CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lbp_pkg.sv */
package lbp_pkg;

    localparam int PIX_W      = 8;
    localparam int IMG_W_BITS = 12;
    localparam int IMG_H_BITS = 13;
    localparam int ROW_BITS   = 12;
    localparam int OCOL_BITS  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [IMG_H_BITS-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [IMG_H_BITS-1:0] MIN_DIM    = 13'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [IMG_W_BITS-1:0] RST_WIDTH  = 12'd640;
    localparam logic [IMG_H_BITS-1:0] RST_HEIGHT = 13'd480;

    typedef logic [PIX_W-1:0] t_pix;

    // Position info of one beat, computed at the input side.
    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [ROW_BITS-1:0]  row;
        logic [OCOL_BITS-1:0] col;
    } t_pos;

    // LBP code: a bit is set where the neighbor is not below the center.
    function automatic t_pix lbp_pattern(
        input t_pix ctr,
        input t_pix tl, input t_pix l, input t_pix bl, input t_pix b,
        input t_pix br, input t_pix r, input t_pix tr, input t_pix t
    );
        t_pix p;
        p[7] = (tl >= ctr);
        p[6] = (l  >= ctr);
        p[5] = (bl >= ctr);
        p[4] = (b  >= ctr);
        p[3] = (br >= ctr);
        p[2] = (r  >= ctr);
        p[1] = (tr >= ctr);
        p[0] = (t  >= ctr);
        return p;
    endfunction

endpackage

/* sv/lbp_3x3_stream_core.sv */
// Channel  Direction  Handshake                 Payload
// pixel    in         i_valid / o_ready         i_pixel, i_frame_start
// result   out        o_valid / i_ready         o_pattern, o_center_row, o_center_col,
//                                               o_last_of_frame
// config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One pixel beat per cycle while the result side does not stall. The line-store read
// port sets the pipeline: stage 0 issues the read, stage 1 compares the 3x3 window
// and writes the store back, then a result goes into the result register.
// Reset is synchronous, active low, and clears counters, window and valid flags;
// line stores are not cleared and need no init pass.
// A stalled result holds a compare-stage beat that has a result, and o_ready drops only when both are full.
`include "assert_macros.svh"

module lbp_3x3_stream_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel beats
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [lbp_pkg::PIX_W-1:0]          i_pixel,
    input  logic                               i_frame_start,
    // result beats
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [lbp_pkg::PIX_W-1:0]          o_pattern,
    output logic [lbp_pkg::ROW_BITS-1:0]       o_center_row,
    output logic [lbp_pkg::OCOL_BITS-1:0]      o_center_col,
    output logic                               o_last_of_frame,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // configuration registers
    logic [lbp_pkg::IMG_W_BITS-1:0] r_image_width;
    logic [lbp_pkg::IMG_H_BITS-1:0] r_image_height;

    // input side
    logic             acc;
    logic [COL_W-1:0] col_c;
    lbp_pkg::t_pos    pos_c;

    // compare stage
    logic             r_s1_valid;
    lbp_pkg::t_pix    r_s1_pix;
    logic [COL_W-1:0] r_s1_col;
    lbp_pkg::t_pos    r_s1_pos;
    logic             r_s1_byp;
    lbp_pkg::t_pix    r_s1_byp_top;
    lbp_pkg::t_pix    r_s1_byp_mid;
    lbp_pkg::t_pix    upper_q, middle_q, s1_top, s1_mid, s1_pattern;
    logic             s1_adv;
    logic             out_free;

    // result register
    logic                            r_o_valid;
    lbp_pkg::t_pix                   r_o_pattern;
    logic [lbp_pkg::ROW_BITS-1:0]    r_o_center_row;
    logic [lbp_pkg::OCOL_BITS-1:0]   r_o_center_col;
    logic                            r_o_last;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= lbp_pkg::RST_WIDTH;
            r_image_height <= lbp_pkg::RST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lbp_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[lbp_pkg::IMG_W_BITS-1:0];
                end
                lbp_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data;
                end
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // ---------------- handshake ----------------
    // Output register is free when empty or being taken; the compare stage
    // moves on when it has no result to give or the output register is free.
    assign out_free = !r_o_valid || i_ready;
    assign s1_adv   = r_s1_valid && (out_free || !r_s1_pos.emit);
    assign o_ready  = !r_s1_valid || s1_adv;
    assign acc      = i_valid && o_ready;

    // ---------------- stage 0: position and store read ----------------
    lbp_ctr #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (acc),
        .i_frame_start  (i_frame_start),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_col          (col_c),
        .o_pos          (pos_c)
    );

    // Upper store takes the old middle row; middle store takes the new pixel.
    // Writes land as the compare stage advances.
    lbp_ram #(
        .WIDTH (lbp_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (s1_mid),
        .i_re    (acc),
        .i_raddr (col_c),
        .o_rdata (upper_q)
    );

    lbp_ram #(
        .WIDTH (lbp_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_re    (acc),
        .i_raddr (col_c),
        .o_rdata (middle_q)
    );

    // A frame restart can revisit the column still being written back in the
    // compare stage; forward that write instead of the stale store data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix     <= i_pixel;
            r_s1_col     <= col_c;
            r_s1_pos     <= pos_c;
            r_s1_byp     <= r_s1_valid && (r_s1_col == col_c);
            r_s1_byp_top <= s1_mid;
            r_s1_byp_mid <= r_s1_pix;
        end
    end

    // ---------------- stage 1: window and compare ----------------
    assign s1_top = r_s1_byp ? r_s1_byp_top : upper_q;
    assign s1_mid = r_s1_byp ? r_s1_byp_mid : middle_q;

    lbp_win u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (s1_adv),
        .i_top     (s1_top),
        .i_mid     (s1_mid),
        .i_pix     (r_s1_pix),
        .o_pattern (s1_pattern)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv && r_s1_pos.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_pos.emit) begin
            r_o_pattern    <= s1_pattern;
            r_o_center_row <= r_s1_pos.row;
            r_o_center_col <= r_s1_pos.col;
            r_o_last       <= r_s1_pos.last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_pattern       = r_o_pattern;
    assign o_center_row    = r_o_center_row;
    assign o_center_col    = r_o_center_col;
    assign o_last_of_frame = r_o_last;

    // ---------------- checks ----------------
    `CHECK_ALWAYS(a_center_interior, !r_o_valid || (r_o_center_row != '0 && r_o_center_col != '0), "result center on the border")
    `CHECK_ALWAYS(a_ready_when_empty, r_s1_valid || o_ready, "input stalled with empty compare stage")
    `CHECK_NEXT(a_s1_hold, r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1_col) && $stable(r_s1_pix), "compare stage lost a stalled beat")

endmodule

/* sv/lbp_ram.sv */
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/lbp_ctr.sv */
module lbp_ctr #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc,
    input  logic                              i_frame_start,
    input  logic [lbp_pkg::IMG_W_BITS-1:0]    i_image_width,
    input  logic [lbp_pkg::IMG_H_BITS-1:0]    i_image_height,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_col,
    output lbp_pkg::t_pos                     o_pos
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = (COL_W + 1 > lbp_pkg::IMG_W_BITS) ? COL_W + 1
                                                             : lbp_pkg::IMG_W_BITS;
    localparam int H_W   = lbp_pkg::IMG_H_BITS;
    localparam logic [CNT_W-1:0] MAX_W_C = CNT_W'(MAX_WIDTH);
    localparam logic [CNT_W-1:0] MIN_W_C = CNT_W'(3);

    logic [COL_W-1:0]               r_col, n_col;
    logic [lbp_pkg::ROW_BITS-1:0]   r_row, n_row;

    logic [CNT_W-1:0] w_raw, w_eff, c0, c1, nc, c_m1;
    logic [H_W-1:0]   h_eff, r0, r1, r2, nr, r_m1;

    always_comb begin
        w_raw = CNT_W'(i_image_width);
        if (w_raw < MIN_W_C) begin
            w_eff = MIN_W_C;
        end else if (w_raw > MAX_W_C) begin
            w_eff = MAX_W_C;
        end else begin
            w_eff = w_raw;
        end

        if (i_image_height < lbp_pkg::MIN_DIM) begin
            h_eff = lbp_pkg::MIN_DIM;
        end else if (i_image_height > lbp_pkg::MAX_HEIGHT) begin
            h_eff = lbp_pkg::MAX_HEIGHT;
        end else begin
            h_eff = i_image_height;
        end

        c0 = i_frame_start ? '0 : CNT_W'(r_col);
        r0 = i_frame_start ? '0 : H_W'(r_row);

        // wrap a counter left beyond the row end
        if (c0 >= w_eff) begin
            c1 = '0;
            r1 = r0 + H_W'(1);
        end else begin
            c1 = c0;
            r1 = r0;
        end
        r2 = (r1 >= h_eff) ? '0 : r1;

        c_m1 = c1 - CNT_W'(1);
        r_m1 = r2 - H_W'(1);

        o_col      = c1[COL_W-1:0];
        o_pos.emit = (r2 >= H_W'(2)) && (c1 >= CNT_W'(2));
        o_pos.last = (r2 == h_eff - H_W'(1)) && (c1 == w_eff - CNT_W'(1));
        o_pos.row  = r_m1[lbp_pkg::ROW_BITS-1:0];
        o_pos.col  = c_m1[lbp_pkg::OCOL_BITS-1:0];

        // advance to the next pixel position
        nc = c1 + CNT_W'(1);
        nr = r2 + H_W'(1);
        if (nc >= w_eff) begin
            n_col = '0;
            n_row = (nr >= h_eff) ? '0 : nr[lbp_pkg::ROW_BITS-1:0];
        end else begin
            n_col = nc[COL_W-1:0];
            n_row = r2[lbp_pkg::ROW_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

/* sv/lbp_win.sv */
module lbp_win (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  lbp_pkg::t_pix i_top,
    input  lbp_pkg::t_pix i_mid,
    input  lbp_pkg::t_pix i_pix,
    output lbp_pkg::t_pix o_pattern
);

    // [0..2] column c-2, [3..5] column c-1; top, middle, bottom
    lbp_pkg::t_pix r_win [6];

    assign o_pattern = lbp_pkg::lbp_pattern(
        r_win[4],
        r_win[0], r_win[1], r_win[2], r_win[5],
        i_pix, i_mid, i_top, r_win[3]
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= i_top;
            r_win[4] <= i_mid;
            r_win[5] <= i_pix;
        end
    end

endmodule
